>>> design/s2d_pkg.sv
// Package for the signed integer to decimal ASCII unit.
// Holds the microcode format, the control store and the shared constants.
// No dependencies.
package s2d_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int CHAR_W         = 6;
  localparam int COUNT_W        = 4;

  localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CODE_ZERO  = 6'd48;

  // Datapath operation selected by the current control word.
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_CONV,
    OP_SKIP,
    OP_SIGN,
    OP_EMIT,
    OP_NOP
  } op_t;

  // Jump condition of a control word; when false the step counter advances.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_IDLE,
    C_ITER,
    C_SKIP,
    C_MORE
  } cond_t;

  typedef logic [2:0] pc_t;

  localparam pc_t P_WAIT = 3'd0;
  localparam pc_t P_CONV = 3'd1;
  localparam pc_t P_SKIP = 3'd2;
  localparam pc_t P_SIGN = 3'd3;
  localparam pc_t P_EMIT = 3'd4;
  localparam pc_t P_END  = 3'd5;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_t  op;
    logic load;
  } s2d_ctrl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic iter_more;
    logic lead_zero;
    logic more_dig;
  } s2d_stat_t;

  // Control store: the whole conversion program.
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      P_WAIT:  w = '{op: OP_WAIT, cond: C_IDLE,   target: P_WAIT};
      P_CONV:  w = '{op: OP_CONV, cond: C_ITER,   target: P_CONV};
      P_SKIP:  w = '{op: OP_SKIP, cond: C_SKIP,   target: P_SKIP};
      P_SIGN:  w = '{op: OP_SIGN, cond: C_NEXT,   target: P_WAIT};
      P_EMIT:  w = '{op: OP_EMIT, cond: C_MORE,   target: P_EMIT};
      P_END:   w = '{op: OP_NOP,  cond: C_ALWAYS, target: P_WAIT};
      default: w = '{op: OP_NOP,  cond: C_ALWAYS, target: P_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> design/s2d_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on s2d_pkg.
module s2d_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  s2d_pkg::s2d_stat_t  stat,
  output s2d_pkg::s2d_ctrl_t  ctrl,
  output logic                busy
);
  import s2d_pkg::*;

  pc_t    pc_r;
  pc_t    pc_nxt;
  uword_t uw;
  logic   take;

  assign uw = ucode_rom(pc_r);

  always_comb begin
    unique case (uw.cond)
      C_NEXT:   take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_IDLE:   take = !start;
      C_ITER:   take = stat.iter_more;
      C_SKIP:   take = stat.lead_zero;
      C_MORE:   take = stat.more_dig;
      default:  take = 1'b1;
    endcase
  end

  assign pc_nxt = take ? uw.target : pc_r + pc_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= P_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.op   = uw.op;
  assign ctrl.load = (uw.op == OP_WAIT) && start;
  assign busy      = (pc_r != P_WAIT);

endmodule

>>> design/s2d_dp.sv
// Conversion datapath: magnitude, BCD accumulator with four bits of
// shift-add-3 per step, digit counters and the registered result ports.
// Depends on s2d_pkg; driven by s2d_seq.
module s2d_dp #(
  parameter int VALUE_BITS = s2d_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  s2d_pkg::s2d_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0]         in_value,
  output s2d_pkg::s2d_stat_t            stat,
  output logic                          out_valid,
  output logic [s2d_pkg::CHAR_W-1:0]    out_char_code,
  output logic                          out_is_last,
  output logic [s2d_pkg::COUNT_W-1:0]   out_char_count
);
  import s2d_pkg::*;

  localparam int STEPS = (VALUE_BITS + 3) / 4;
  localparam int MAG_W = STEPS * 4;
  localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int IT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int RD_W  = $clog2(NDIG + 1);

  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic               neg_r, neg_nxt;
  logic [IT_W-1:0]    it_r, it_nxt;
  logic [RD_W-1:0]    rem_r, rem_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  logic               ov_r, ov_nxt;
  logic [CHAR_W-1:0]  oc_r, oc_nxt;
  logic               ol_r, ol_nxt;
  logic [COUNT_W-1:0] on_r, on_nxt;

  logic [VALUE_BITS-1:0] mag_in;
  logic [BCD_W-1:0]      bcd_dab;
  logic [MAG_W-1:0]      mag_dab;
  logic [3:0]            top_dig;
  logic                  last_dig;

  assign mag_in   = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
  assign top_dig  = bcd_r[BCD_W-1 -: 4];
  assign last_dig = (rem_r == RD_W'(1));

  // Four double-dabble bit steps per cycle.
  always_comb begin
    bcd_dab = bcd_r;
    mag_dab = mag_r;
    for (int b = 0; b < 4; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_dab[d*4 +: 4] >= 4'd5) begin
          bcd_dab[d*4 +: 4] = bcd_dab[d*4 +: 4] + 4'd3;
        end
      end
      bcd_dab = {bcd_dab[BCD_W-2:0], mag_dab[MAG_W-1]};
      mag_dab = {mag_dab[MAG_W-2:0], 1'b0};
    end
  end

  assign stat.iter_more = (it_r != '0);
  assign stat.lead_zero = (top_dig == 4'd0) && !last_dig;
  assign stat.more_dig  = !last_dig;

  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    it_nxt  = it_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    ov_nxt  = 1'b0;
    oc_nxt  = oc_r;
    ol_nxt  = 1'b0;
    on_nxt  = '0;
    unique case (ctrl.op)
      OP_WAIT: begin
        if (ctrl.load) begin
          mag_nxt = MAG_W'(mag_in);
          bcd_nxt = '0;
          neg_nxt = in_value[VALUE_BITS-1];
          it_nxt  = IT_W'(STEPS - 1);
          rem_nxt = RD_W'(NDIG);
        end
      end
      OP_CONV: begin
        mag_nxt = mag_dab;
        bcd_nxt = bcd_dab;
        it_nxt  = it_r - IT_W'(1);
      end
      OP_SKIP: begin
        if (stat.lead_zero) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          rem_nxt = rem_r - RD_W'(1);
        end
      end
      OP_SIGN: begin
        cnt_nxt = COUNT_W'(rem_r) + COUNT_W'(neg_r);
        ov_nxt  = neg_r;
        oc_nxt  = CODE_MINUS;
      end
      OP_EMIT: begin
        bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
        rem_nxt = rem_r - RD_W'(1);
        ov_nxt  = 1'b1;
        oc_nxt  = CODE_ZERO + CHAR_W'(top_dig);
        ol_nxt  = last_dig;
        on_nxt  = last_dig ? cnt_r : '0;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
    it_r  <= it_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
    on_r  <= on_nxt;
  end

  assign out_valid      = ov_r;
  assign out_char_code  = oc_r;
  assign out_is_last    = ol_r;
  assign out_char_count = on_r;

endmodule

>>> design/signed_int_to_decimal_ascii_unit.sv
// Top level of the signed integer to decimal ASCII unit.
// Instantiates the microcode sequencer s2d_seq and the datapath s2d_dp;
// depends on s2d_pkg.
//
//   Channel   Ports                                         Handshake
//   input     in_value                                      start, busy
//   result    out_char_code, out_is_last, out_char_count    out_valid
//
// A transaction on the input is taken at a rising edge where start is high
// and busy is low. The conversion then runs the BCD conversion loop, four
// bits per cycle, the one-digit-per-cycle leading-zero skip loop, the sign
// step and the one-digit-per-cycle emit loop of up to NDIG digits, where NDIG
// is the decimal digit capacity; its length depends on the value. Characters
// appear one per cycle, each for exactly one cycle with out_valid high; the
// receiver cannot stall. Reset is synchronous and active low and returns the
// sequencer to its wait step with no result pending.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = s2d_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [VALUE_BITS-1:0]         in_value,
  output logic                          out_valid,
  output logic [s2d_pkg::CHAR_W-1:0]    out_char_code,
  output logic                          out_is_last,
  output logic [s2d_pkg::COUNT_W-1:0]   out_char_count
);
  import s2d_pkg::*;

  s2d_ctrl_t ctrl;
  s2d_stat_t stat;

  // The sequencer walks the control store: wait for a transaction, run the
  // BCD conversion, drop leading zero digits, emit a minus sign for a negative value, emit the digits.
  s2d_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // The datapath holds the magnitude and BCD digits and registers each
  // character, so results leave in the cycle after the step that made them.
  s2d_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_value       (in_value),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_char_code  (out_char_code),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count)
  );

  // A character only ever leaves while a conversion is in progress.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a conversion");

  // An accepted transaction starts a conversion.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start a conversion");

  // The count is carried on the final character only, and is never zero there.
  a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_last) |-> (out_char_count != '0))
    else $error("zero count on final character");

  a_count_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_last) |-> (out_char_count == '0))
    else $error("count on a non-final character");

  // Every character is a minus sign or a decimal digit.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_code == CODE_MINUS) ||
                   ((out_char_code >= CODE_ZERO) &&
                    (out_char_code <= CODE_ZERO + CHAR_W'(9)))))
    else $error("character code out of range");

  // In the cycle after the last character the unit is free again.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_last) |=> !busy)
    else $error("conversion did not end after the final character");

endmodule
